[rtl/protobuf_field_stream_decoder_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the protobuf field stream decoder
// Concurrent assertion wrappers that compile away when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef PROTOBUF_FIELD_STREAM_DECODER_ASSERT_SVH
`define PROTOBUF_FIELD_STREAM_DECODER_ASSERT_SVH

`ifndef ASSERT_OFF
// Checked on every rising edge, switched off while reset is held.
`define PFSD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every rising edge, reset included.
`define PFSD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PFSD_ASSERT(lbl, clk, rst_n, prop, msg)
`define PFSD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

[rtl/pfsd_pkg.sv]
// ----------------------------------------------------------------------------
// Protobuf field stream decoder package
// Field widths and the result, error and wire type codes shared by the design.
// ----------------------------------------------------------------------------
`default_nettype none

package pfsd_pkg;

    // Field widths of the transactions.
    localparam int DataW   = 8;
    localparam int KindW   = 2;
    localparam int FieldW  = 29;
    localparam int TypeW   = 3;
    localparam int ValueW  = 64;
    localparam int ErrW    = 3;
    localparam int LenW    = 31;
    localparam int IdxW    = 4;

    // A value or length varint may have at most this many bytes.
    localparam int MaxVarintBytes = 10;
    // Number of varint bytes with bits that still land inside 64 bits.
    localparam int AccumVarintBytes = 10;
    // A tag may use at most this many bytes.
    localparam int MaxTagBytes = 5;

    // Reset value of the payload length limit.
    localparam logic [LenW-1:0] MaxLenReset = {LenW{1'b1}};

    // Result kinds.
    typedef enum logic [KindW-1:0] {
        K_SCALAR = 2'd0,
        K_HEADER = 2'd1,
        K_BYTE   = 2'd2,
        K_ERROR  = 2'd3
    } t_kind;

    // Error codes.
    typedef enum logic [ErrW-1:0] {
        E_NONE  = 3'd0,
        E_TYPE  = 3'd1,
        E_LONG  = 3'd2,
        E_TRUNC = 3'd3,
        E_LIMIT = 3'd4
    } t_err;

    // Wire types that the decoder knows.
    typedef enum logic [TypeW-1:0] {
        WT_VARINT = 3'd0,
        WT_I64    = 3'd1,
        WT_LEN    = 3'd2,
        WT_I32    = 3'd5
    } t_wire;

endpackage

`default_nettype wire

[rtl/pfsd_if.sv]
// ----------------------------------------------------------------------------
// Protobuf field stream decoder channels
// Valid/ready channels for input bytes, decoded results and configuration.
// ----------------------------------------------------------------------------
`default_nettype none

// Input byte channel.
interface pfsd_in_if import pfsd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DataW-1:0]  data_byte;
    logic              final_byte;

    modport source (output valid, output data_byte, output final_byte, input ready);
    modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

// Decoded result channel.
interface pfsd_out_if import pfsd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KindW-1:0]  result_kind;
    logic [FieldW-1:0] field_id;
    logic [TypeW-1:0]  wire_code;
    logic [ValueW-1:0] field_value;
    logic [DataW-1:0]  payload_data;
    logic              end_of_field;
    logic [ErrW-1:0]   error_code;

    modport source (
        output valid, output result_kind, output field_id, output wire_code,
        output field_value, output payload_data, output end_of_field,
        output error_code, input ready
    );
    modport sink (
        input valid, input result_kind, input field_id, input wire_code,
        input field_value, input payload_data, input end_of_field,
        input error_code, output ready
    );
endinterface

// Configuration write channel for the payload length limit.
interface pfsd_cfg_if import pfsd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [LenW-1:0]   max_payload_length;

    modport source (output valid, output max_payload_length, input ready);
    modport sink   (input valid, input max_payload_length, output ready);
endinterface

`default_nettype wire

[rtl/protobuf_field_stream_decoder.sv]
// A result is registered and shows in the cycle after its byte is accepted.
// Throughput: one byte per cycle unless the output stalls; decode in a single pass.
// The output register holds one result; a stalled consumer holds off new bytes.
// Reset: synchronous, active low; returns to the tag phase, limit to 2^31-1.
// Configuration writes are taken in any cycle.
// ----------------------------------------------------------------------------
// Protobuf field stream decoder
// Decodes protobuf wire format fields from a byte stream into field results.
// ----------------------------------------------------------------------------
`default_nettype none

`include "protobuf_field_stream_decoder_assert.svh"

module protobuf_field_stream_decoder import pfsd_pkg::*; #(
    parameter int MaxVarint = MaxVarintBytes
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    pfsd_in_if.sink    i_in,
    pfsd_cfg_if.sink   i_cfg,
    pfsd_out_if.source o_out
);

    // Decoder phases, one-hot.
    typedef enum logic [5:0] {
        PH_TAG     = 6'b000001,
        PH_VARINT  = 6'b000010,
        PH_FIXED   = 6'b000100,
        PH_LEN     = 6'b001000,
        PH_PAYLOAD = 6'b010000,
        PH_DROP    = 6'b100000
    } t_phase;

    // Decode state.
    t_phase              r_phase, n_phase;
    logic [ValueW-1:0]   r_acc, n_acc;
    logic [IdxW-1:0]     r_bidx, n_bidx;
    logic [FieldW-1:0]   r_field, n_field;
    logic [TypeW-1:0]    r_type, n_type;
    logic [LenW-1:0]     r_rem, n_rem;
    logic [LenW-1:0]     r_max_len;

    // Output register.
    logic                r_out_valid;
    t_kind               r_kind, n_kind;
    logic [FieldW-1:0]   r_res_field, n_res_field;
    logic [TypeW-1:0]    r_res_type, n_res_type;
    logic [ValueW-1:0]   r_value, n_value;
    logic [DataW-1:0]    r_pay, n_pay;
    logic                r_eof, n_eof;
    t_err                r_err, n_err;

    // Handshake and per-byte decode signals.
    logic                w_in_acc;
    logic                w_emit;
    logic                w_fail;
    logic                w_fail_tag;
    t_err                w_fail_code;
    logic                w_more;
    logic                w_fin;
    logic [DataW-1:0]    w_b;
    logic [IdxW-1:0]     w_k;
    logic [2:0]          w_kt;
    logic [6:0]          w_sh_var;
    logic [5:0]          w_sh_tag;
    logic [5:0]          w_sh_fix;
    logic [ValueW-1:0]   w_acc_var;
    logic [ValueW-1:0]   w_acc_fix;
    logic [ValueW-1:0]   w_acc_tag;
    logic [LenW-1:0]     w_rem_dec;
    logic                w_var_long;
    logic                w_tag_long;

    // A byte is taken whenever the output register is free or being emptied.
    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign w_in_acc    = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    assign w_b    = i_in.data_byte;
    assign w_fin  = i_in.final_byte;
    assign w_more = w_b[DataW-1];
    assign w_k    = r_bidx;

    // Varint accumulation: seven bits at offset 7*k, dropped past bit 63.
    assign w_sh_var  = {w_k, 3'b000} - {3'b000, w_k};
    assign w_acc_var = (w_k < IdxW'(AccumVarintBytes))
                     ? (r_acc | (ValueW'(w_b[6:0]) << w_sh_var)) : r_acc;
    assign w_var_long = ({1'b0, w_k} + 5'd1) >= 5'(MaxVarint);

    // Fixed-width accumulation: little-endian byte at offset 8*k.
    assign w_sh_fix  = {w_k[2:0], 3'b000};
    assign w_acc_fix = r_acc | (ValueW'(w_b) << w_sh_fix);
    assign w_rem_dec = r_rem - LenW'(1);

    // Tag accumulation with the byte position clamped to the last tag byte.
    assign w_kt       = (w_k > IdxW'(MaxTagBytes - 1)) ? 3'(MaxTagBytes - 1) : w_k[2:0];
    assign w_sh_tag   = {w_kt, 3'b000} - {3'b000, w_kt};
    assign w_acc_tag  = r_acc | (ValueW'(w_b[6:0]) << w_sh_tag);
    assign w_tag_long = (w_kt == 3'(MaxTagBytes - 1)) && (w_more || (w_b[6:4] != 3'b000));

    // Next decode state and the result caused by the current byte.
    always_comb begin
        n_phase     = r_phase;
        n_acc       = r_acc;
        n_bidx      = r_bidx;
        n_field     = r_field;
        n_type      = r_type;
        n_rem       = r_rem;
        w_emit      = 1'b0;
        n_kind      = K_SCALAR;
        n_value     = '0;
        n_pay       = '0;
        n_eof       = 1'b0;
        n_err       = E_NONE;
        n_res_field = r_field;
        n_res_type  = r_type;
        w_fail      = 1'b0;
        w_fail_tag  = 1'b0;
        w_fail_code = E_NONE;

        unique case (r_phase)
            PH_VARINT, PH_LEN: begin
                n_acc = w_acc_var;
                if (w_more) begin
                    if (w_var_long) begin
                        w_fail      = 1'b1;
                        w_fail_code = E_LONG;
                    end else if (w_fin) begin
                        w_fail      = 1'b1;
                        w_fail_code = E_TRUNC;
                    end else begin
                        n_bidx = w_k + IdxW'(1);
                    end
                end else begin
                    n_bidx = '0;
                    if (r_phase == PH_VARINT) begin
                        w_emit  = 1'b1;
                        n_kind  = K_SCALAR;
                        n_value = w_acc_var;
                        n_eof   = 1'b1;
                        n_phase = PH_TAG;
                        n_acc   = '0;
                    end else if (w_acc_var > ValueW'(r_max_len)) begin
                        w_fail      = 1'b1;
                        w_fail_code = E_LIMIT;
                    end else if (w_acc_var == '0) begin
                        w_emit  = 1'b1;
                        n_kind  = K_HEADER;
                        n_eof   = 1'b1;
                        n_phase = PH_TAG;
                    end else if (w_fin) begin
                        w_fail      = 1'b1;
                        w_fail_code = E_TRUNC;
                    end else begin
                        w_emit  = 1'b1;
                        n_kind  = K_HEADER;
                        n_value = w_acc_var;
                        n_rem   = w_acc_var[LenW-1:0];
                        n_acc   = '0;
                        n_phase = PH_PAYLOAD;
                    end
                end
            end
            PH_FIXED: begin
                n_acc  = w_acc_fix;
                n_bidx = w_k + IdxW'(1);
                n_rem  = w_rem_dec;
                if (w_rem_dec != '0) begin
                    if (w_fin) begin
                        w_fail      = 1'b1;
                        w_fail_code = E_TRUNC;
                    end
                end else begin
                    w_emit  = 1'b1;
                    n_kind  = K_SCALAR;
                    n_value = w_acc_fix;
                    n_eof   = 1'b1;
                    n_phase = PH_TAG;
                    n_acc   = '0;
                    n_bidx  = '0;
                end
            end
            PH_PAYLOAD: begin
                n_rem = w_rem_dec;
                if ((w_rem_dec != '0) && w_fin) begin
                    w_fail      = 1'b1;
                    w_fail_code = E_TRUNC;
                end else begin
                    w_emit = 1'b1;
                    n_kind = K_BYTE;
                    n_pay  = w_b;
                    n_eof  = (w_rem_dec == '0);
                    if (w_rem_dec == '0) begin
                        n_phase = PH_TAG;
                    end
                end
            end
            PH_DROP: begin
                if (w_fin) begin
                    n_phase = PH_TAG;
                end
            end
            default: begin
                // Tag phase; codes that mean nothing act the same.
                n_phase = PH_TAG;
                if (w_tag_long) begin
                    w_fail      = 1'b1;
                    w_fail_tag  = 1'b1;
                    w_fail_code = E_LONG;
                end else if (w_more) begin
                    n_acc = w_acc_tag;
                    if (w_fin) begin
                        w_fail      = 1'b1;
                        w_fail_tag  = 1'b1;
                        w_fail_code = E_TRUNC;
                    end else begin
                        n_bidx = IdxW'(w_kt) + IdxW'(1);
                    end
                end else begin
                    n_field = w_acc_tag[FieldW+TypeW-1:TypeW];
                    n_type  = w_acc_tag[TypeW-1:0];
                    n_acc   = '0;
                    n_bidx  = '0;
                    unique case (w_acc_tag[TypeW-1:0])
                        WT_VARINT: n_phase = PH_VARINT;
                        WT_I64: begin
                            n_phase = PH_FIXED;
                            n_rem   = LenW'(8);
                        end
                        WT_LEN:    n_phase = PH_LEN;
                        WT_I32: begin
                            n_phase = PH_FIXED;
                            n_rem   = LenW'(4);
                        end
                        default: begin
                            w_fail      = 1'b1;
                            w_fail_code = E_TYPE;
                        end
                    endcase
                    if (!w_fail && w_fin) begin
                        w_fail      = 1'b1;
                        w_fail_code = E_TRUNC;
                    end
                end
            end
        endcase

        // Error result: the field is dropped up to the final byte.
        if (w_fail) begin
            w_emit      = 1'b1;
            n_kind      = K_ERROR;
            n_res_field = w_fail_tag ? '0 : n_field;
            n_res_type  = w_fail_tag ? '0 : n_type;
            n_value     = '0;
            n_pay       = '0;
            n_eof       = 1'b1;
            n_err       = w_fail_code;
            n_phase     = w_fin ? PH_TAG : PH_DROP;
            n_acc       = '0;
            n_bidx      = '0;
            n_rem       = '0;
        end else begin
            n_res_field = r_field;
            n_res_type  = r_type;
        end
    end

    // Decode state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_TAG;
            r_acc   <= '0;
            r_bidx  <= '0;
            r_field <= '0;
            r_type  <= '0;
            r_rem   <= '0;
        end else if (w_in_acc) begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_bidx  <= n_bidx;
            r_field <= n_field;
            r_type  <= n_type;
            r_rem   <= n_rem;
        end
    end

    // Payload length limit register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= MaxLenReset;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_max_len <= i_cfg.max_payload_length;
        end
    end

    // Output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_acc && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload register.
    always_ff @(posedge i_clk) begin
        if (w_in_acc && w_emit) begin
            r_kind      <= n_kind;
            r_res_field <= n_res_field;
            r_res_type  <= n_res_type;
            r_value     <= n_value;
            r_pay       <= n_pay;
            r_eof       <= n_eof;
            r_err       <= n_err;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.result_kind  = r_kind;
    assign o_out.field_id     = r_res_field;
    assign o_out.wire_code    = r_res_type;
    assign o_out.field_value  = r_value;
    assign o_out.payload_data = r_pay;
    assign o_out.end_of_field = r_eof;
    assign o_out.error_code   = r_err;

    // A payload phase always has bytes left to take.
    `PFSD_ASSERT(a_payload_left, i_clk, i_rst_n,
        (r_phase == PH_PAYLOAD) |-> (r_rem != '0), "payload phase with no bytes left")

    // A varint never runs past its byte limit.
    `PFSD_ASSERT(a_varint_index, i_clk, i_rst_n,
        ((r_phase == PH_VARINT) || (r_phase == PH_LEN)) |-> (r_bidx < IdxW'(MaxVarint)),
        "varint byte index past limit")

    // Dropped bytes give no result.
    `PFSD_ASSERT(a_drop_silent, i_clk, i_rst_n,
        (w_in_acc && (r_phase == PH_DROP)) |=> !r_out_valid, "result produced while dropping")

    // An error on a byte that is not final leads to the drop phase.
    `PFSD_ASSERT(a_error_drop, i_clk, i_rst_n,
        (w_in_acc && w_fail && !w_fin)
            |=> ((r_phase == PH_DROP) && r_out_valid && (r_kind == K_ERROR)),
        "error did not enter drop phase")

endmodule

`default_nettype wire
